/* hdl/sbcb_pkg.sv */
// sbcb_pkg: shared types and constants for the smooth band color blend core
// no dependencies; imported by every module of the block
package sbcb_pkg;

   // fixed field widths
   localparam int SAMPLE_W  = 16;
   localparam int EDGE_W    = 18;
   localparam int DIV_W     = 17;
   localparam int CHAN_W    = 16;
   localparam int NUM_CHAN  = 4;
   localparam int COLOR_W   = CHAN_W * NUM_CHAN;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_SOFT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_SOFT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INSIDE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTSIDE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT     = 3'd6;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_LOWER_THR  = 16'd1638;
   localparam logic [SAMPLE_W-1:0] RST_UPPER_THR  = 16'd2048;
   localparam logic [SAMPLE_W-1:0] RST_LOWER_SOFT = 16'd205;
   localparam logic [SAMPLE_W-1:0] RST_UPPER_SOFT = 16'd205;
   localparam logic [COLOR_W-1:0]  RST_INSIDE     = 64'hFFFF_0000_0000_0000;
   localparam logic [COLOR_W-1:0]  RST_OUTSIDE    = 64'h0000_0000_0000_1000;

   // where a sample sits against the band
   typedef logic [1:0] zone_type;
   localparam zone_type ZONE_INSIDE  = 2'd0;
   localparam zone_type ZONE_OUTSIDE = 2'd1;
   localparam zone_type ZONE_RAMP_LO = 2'd2;
   localparam zone_type ZONE_RAMP_HI = 2'd3;

   // band edge settings
   typedef struct packed {
      logic [SAMPLE_W-1:0] lower_thr;
      logic [SAMPLE_W-1:0] upper_thr;
      logic [SAMPLE_W-1:0] lower_soft;
      logic [SAMPLE_W-1:0] upper_soft;
   } band_cfg_type;

   // color settings
   typedef struct packed {
      logic [COLOR_W-1:0] inner;
      logic [COLOR_W-1:0] outside;
      logic               invert;
   } color_cfg_type;

endpackage

/* hdl/sbcb_edge.sv */
// sbcb_edge: band edge setup and sample classification, two pipeline stages
// depends on sbcb_pkg
module sbcb_edge import sbcb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  band_cfg_type       band_cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   output logic               out_valid,
   input  logic               out_ready,
   output zone_type           out_zone,
   output logic [DIV_W-1:0]   out_num,
   output logic [DIV_W-1:0]   out_den
);

   logic                     v1_ff, v2_ff;
   logic                     en1, en2;
   logic signed [EDGE_W-1:0] lt0, ut0, lo0, hi0, ltc;
   logic signed [EDGE_W-1:0] lo_in, lt_in, ut_in, hi_in;
   logic signed [EDGE_W-1:0] x_ff, lo_ff, lt_ff, ut_ff, hi_ff;
   logic signed [EDGE_W-1:0] d_lo, d_lt, d_ut, d_hi;
   zone_type                 zone_in, zone_ff;
   logic [DIV_W-1:0]         num_in, den_in, num_ff, den_ff;

   // stall chain
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // outer edges, clamp and swap
   always_comb begin
      lt0 = EDGE_W'($signed(band_cfg.lower_thr));
      ut0 = EDGE_W'($signed(band_cfg.upper_thr));
      lo0 = lt0 - EDGE_W'($signed(band_cfg.lower_soft));
      hi0 = ut0 + EDGE_W'($signed(band_cfg.upper_soft));
      ltc = (lt0 > ut0) ? ut0 : lt0;
      if (ltc < lo0) begin
         lo_in = ltc;
         lt_in = lo0;
      end else begin
         lo_in = lo0;
         lt_in = ltc;
      end
      if (ut0 > hi0) begin
         ut_in = hi0;
         hi_in = ut0;
      end else begin
         ut_in = ut0;
         hi_in = hi0;
      end
   end

   // stage 1: sample and edges
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         x_ff  <= EDGE_W'($signed(in_sample));
         lo_ff <= lo_in;
         lt_ff <= lt_in;
         ut_ff <= ut_in;
         hi_ff <= hi_in;
      end
   end

   // classification and ramp operands
   always_comb begin
      d_lo = x_ff - lo_ff;
      d_lt = lt_ff - lo_ff;
      d_ut = x_ff - ut_ff;
      d_hi = hi_ff - ut_ff;
      num_in = '0;
      den_in = DIV_W'(1);
      if (x_ff >= lt_ff && x_ff <= ut_ff) begin
         zone_in = ZONE_INSIDE;
      end else if (x_ff <= lo_ff || x_ff >= hi_ff) begin
         zone_in = ZONE_OUTSIDE;
      end else if (x_ff < lt_ff) begin
         zone_in = ZONE_RAMP_LO;
         num_in  = d_lo[DIV_W-1:0];
         den_in  = d_lt[DIV_W-1:0];
      end else begin
         zone_in = ZONE_RAMP_HI;
         num_in  = d_ut[DIV_W-1:0];
         den_in  = d_hi[DIV_W-1:0];
      end
   end

   // stage 2: zone and divider operands
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         zone_ff <= zone_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_zone  = zone_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

/* hdl/sbcb_div.sv */
// sbcb_div: pipelined restoring divider, one quotient bit per stage
// depends on sbcb_pkg; gives t = floor(num * 2^FRAC_BITS / den) for num < den
module sbcb_div import sbcb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  zone_type             in_zone,
   input  logic [DIV_W-1:0]     in_num,
   input  logic [DIV_W-1:0]     in_den,
   output logic                 out_valid,
   input  logic                 out_ready,
   output zone_type             out_zone,
   output logic [FRAC_BITS-1:0] out_quot
);

   wire  [FRAC_BITS:0]   en;
   logic                 v_ff    [FRAC_BITS];
   zone_type             zone_ff [FRAC_BITS];
   logic [DIV_W-1:0]     rem_ff  [FRAC_BITS];
   logic [DIV_W-1:0]     den_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff    [FRAC_BITS];

   assign en[FRAC_BITS] = out_ready;
   assign in_ready      = en[0];

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
      logic                 v_prev;
      zone_type             zone_prev;
      logic [DIV_W-1:0]     rem_prev, den_prev, rem_in;
      logic [FRAC_BITS-1:0] q_prev, q_in;
      logic [DIV_W:0]       r2;
      logic                 ge;

      // stage input: module port or previous stage
      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign zone_prev = in_zone;
         assign rem_prev  = in_num;
         assign den_prev  = in_den;
         assign q_prev    = '0;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign zone_prev = zone_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign q_prev    = q_ff[s-1];
      end

      assign en[s] = !v_ff[s] || en[s+1];

      // one shift, compare and subtract step
      always_comb begin
         r2     = {rem_prev, 1'b0};
         ge     = (r2 >= {1'b0, den_prev});
         rem_in = ge ? DIV_W'(r2 - {1'b0, den_prev}) : r2[DIV_W-1:0];
         q_in   = {q_prev[FRAC_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= v_prev;
         end
         if (en[s]) begin
            zone_ff[s] <= zone_prev;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_prev;
            q_ff[s]    <= q_in;
         end
      end
   end

   assign out_valid = v_ff[FRAC_BITS-1];
   assign out_zone  = zone_ff[FRAC_BITS-1];
   assign out_quot  = q_ff[FRAC_BITS-1];

endmodule

/* hdl/sbcb_weight.sv */
// sbcb_weight: smoothstep weight 3t^2-2t^3 over three pipeline stages
// depends on sbcb_pkg; fixes the weight for inside and outside samples
module sbcb_weight import sbcb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  zone_type             in_zone,
   input  logic [FRAC_BITS-1:0] in_t,
   output logic                 out_valid,
   input  logic                 out_ready,
   output zone_type             out_zone,
   output logic [FRAC_BITS:0]   out_weight
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic                       v1_ff, v2_ff, v3_ff;
   logic                       en1, en2, en3;
   zone_type                   zone1_ff, zone2_ff, zone3_ff;
   logic [FRAC_BITS-1:0]       t1_ff, t2a_ff, t2b_ff, t3_ff;
   logic [2*FRAC_BITS-1:0]     sq, cube;
   logic [FRAC_BITS+1:0]       tri3;
   logic [FRAC_BITS:0]         dbl;
   logic signed [FRAC_BITS+2:0] w_raw;
   logic [FRAC_BITS:0]         w_sat, w_in, w_ff;

   // stall chain
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: t squared
   assign sq = (2*FRAC_BITS)'(in_t) * (2*FRAC_BITS)'(in_t);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         zone1_ff <= in_zone;
         t1_ff    <= in_t;
         t2a_ff   <= sq[2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   // stage 2: t cubed
   assign cube = (2*FRAC_BITS)'(t2a_ff) * (2*FRAC_BITS)'(t1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         zone2_ff <= zone1_ff;
         t2b_ff   <= t2a_ff;
         t3_ff    <= cube[2*FRAC_BITS-1:FRAC_BITS];
      end
   end

   // stage 3: weight, saturation, upper ramp inversion, fixed inside and outside weights
   always_comb begin
      tri3  = {2'b00, t2b_ff} + {1'b0, t2b_ff, 1'b0};
      dbl   = {t3_ff, 1'b0};
      w_raw = $signed({1'b0, tri3}) - $signed({2'b00, dbl});
      if (w_raw < 0) begin
         w_sat = '0;
      end else if (w_raw > $signed({2'b00, ONE})) begin
         w_sat = ONE;
      end else begin
         w_sat = w_raw[FRAC_BITS:0];
      end
      case (zone2_ff)
         ZONE_INSIDE:  w_in = ONE;
         ZONE_OUTSIDE: w_in = '0;
         ZONE_RAMP_LO: w_in = w_sat;
         ZONE_RAMP_HI: w_in = ONE - w_sat;
         default:      w_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         zone3_ff <= zone2_ff;
         w_ff     <= w_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_zone   = zone3_ff;
   assign out_weight = w_ff;

endmodule

/* hdl/sbcb_mix.sv */
// sbcb_mix: per channel color blend, products then rounded saturating sum
// depends on sbcb_pkg; its second stage is the result register of the core
module sbcb_mix import sbcb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  color_cfg_type                    color_cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [FRAC_BITS:0]               in_weight,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [NUM_CHAN-1:0][CHAN_W-1:0]  out_chan
);

   localparam int PW = CHAN_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW:0]        HALF = (PW+1)'(1) << (FRAC_BITS - 1);

   logic               v1_ff, v2_ff;
   logic               en1, en2;
   logic [COLOR_W-1:0] col_a, col_b;
   logic [FRAC_BITS:0] w_inv;
   logic [PW-1:0]      pa_ff [NUM_CHAN];
   logic [PW-1:0]      pb_ff [NUM_CHAN];
   logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_ff;

   // stall chain
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // color at zero weight is a, at full weight b
   assign col_a = color_cfg.invert ? color_cfg.inner : color_cfg.outside;
   assign col_b = color_cfg.invert ? color_cfg.outside : color_cfg.inner;
   assign w_inv = ONE - in_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
      logic [CHAN_W-1:0] ca, cb;
      logic [PW:0]       sum;
      logic [CHAN_W+1:0] r;

      assign ca = col_a[COLOR_W-1-CHAN_W*k -: CHAN_W];
      assign cb = col_b[COLOR_W-1-CHAN_W*k -: CHAN_W];

      // stage 1: the two weighted products
      always_ff @(posedge clock) begin
         if (en1) begin
            pa_ff[k] <= PW'(ca) * PW'(w_inv);
            pb_ff[k] <= PW'(cb) * PW'(in_weight);
         end
      end

      // stage 2: round, scale, saturate
      assign sum = {1'b0, pa_ff[k]} + {1'b0, pb_ff[k]} + HALF;
      assign r   = sum[PW:FRAC_BITS];

      always_ff @(posedge clock) begin
         if (en2) begin
            chan_ff[k] <= (|r[CHAN_W+1:CHAN_W]) ? {CHAN_W{1'b1}} : r[CHAN_W-1:0];
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_chan  = chan_ff;

endmodule

/* hdl/smooth_band_color_blend_core.sv */
// throughput: one item per cycle while rsp_ready holds; the divider computes one quotient bit per stage,
//   so its FRAC_BITS stages set the depth, and a stage holds only while it is full and the stage after it holds
// reset: synchronous, active high; clears all valid bits and loads the register
//   defaults; no clearing pass, items are accepted in the cycle after reset
module smooth_band_color_blend_core import sbcb_pkg::*; #(
   parameter int FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_sample_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAN_W-1:0]    rsp_out_red,
   output logic [CHAN_W-1:0]    rsp_out_green,
   output logic [CHAN_W-1:0]    rsp_out_blue,
   output logic [CHAN_W-1:0]    rsp_out_alpha,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wr_data
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   band_cfg_type               band_ff;
   color_cfg_type              color_ff;
   logic                       edge_valid, edge_ready;
   zone_type                   edge_zone;
   logic [DIV_W-1:0]           edge_num, edge_den;
   logic                       div_valid, div_ready;
   zone_type                   div_zone;
   logic [FRAC_BITS-1:0]       div_quot;
   logic                       wt_valid, wt_ready;
   zone_type                   wt_zone;
   logic [FRAC_BITS:0]         wt_weight;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] mix_chan;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff.lower_thr  <= RST_LOWER_THR;
         band_ff.upper_thr  <= RST_UPPER_THR;
         band_ff.lower_soft <= RST_LOWER_SOFT;
         band_ff.upper_soft <= RST_UPPER_SOFT;
         color_ff.inner     <= RST_INSIDE;
         color_ff.outside   <= RST_OUTSIDE;
         color_ff.invert    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_LOWER_THR:  band_ff.lower_thr  <= csr_wr_data[SAMPLE_W-1:0];
            REG_UPPER_THR:  band_ff.upper_thr  <= csr_wr_data[SAMPLE_W-1:0];
            REG_LOWER_SOFT: band_ff.lower_soft <= csr_wr_data[SAMPLE_W-1:0];
            REG_UPPER_SOFT: band_ff.upper_soft <= csr_wr_data[SAMPLE_W-1:0];
            REG_INSIDE:     color_ff.inner     <= csr_wr_data;
            REG_OUTSIDE:    color_ff.outside   <= csr_wr_data;
            REG_INVERT:     color_ff.invert    <= csr_wr_data[0];
            default:        ;
         endcase
      end
   end

   // edge setup and classification
   sbcb_edge u_edge (
      .clock     (clock),
      .reset     (reset),
      .band_cfg  (band_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_sample_value),
      .out_valid (edge_valid),
      .out_ready (edge_ready),
      .out_zone  (edge_zone),
      .out_num   (edge_num),
      .out_den   (edge_den)
   );

   // ramp position
   sbcb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (edge_valid),
      .in_ready  (edge_ready),
      .in_zone   (edge_zone),
      .in_num    (edge_num),
      .in_den    (edge_den),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_zone  (div_zone),
      .out_quot  (div_quot)
   );

   // smoothstep weight
   sbcb_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_zone    (div_zone),
      .in_t       (div_quot),
      .out_valid  (wt_valid),
      .out_ready  (wt_ready),
      .out_zone   (wt_zone),
      .out_weight (wt_weight)
   );

   // color blend and result register
   sbcb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
      .clock     (clock),
      .reset     (reset),
      .color_cfg (color_ff),
      .in_valid  (wt_valid),
      .in_ready  (wt_ready),
      .in_weight (wt_weight),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_chan  (mix_chan)
   );

   assign rsp_out_red   = mix_chan[0];
   assign rsp_out_green = mix_chan[1];
   assign rsp_out_blue  = mix_chan[2];
   assign rsp_out_alpha = mix_chan[3];

`ifndef SYNTHESIS
   // an empty result register lets the whole pipeline move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   // ramp operands keep the quotient below one
   a_ramp_operands: assert property (@(posedge clock) disable iff (reset)
      (edge_valid && (edge_zone == ZONE_RAMP_LO || edge_zone == ZONE_RAMP_HI))
      |-> (edge_num != '0 && edge_num < edge_den))
      else $error("ramp numerator out of range");

   // weight never exceeds one
   a_weight_bound: assert property (@(posedge clock) disable iff (reset)
      wt_valid |-> (wt_weight <= ONE))
      else $error("blend weight above one");

   // inside samples get full weight, outside samples none
   a_weight_fixed: assert property (@(posedge clock) disable iff (reset)
      wt_valid |-> ((wt_zone != ZONE_INSIDE || wt_weight == ONE)
                    && (wt_zone != ZONE_OUTSIDE || wt_weight == '0)))
      else $error("fixed weight wrong for inside or outside item");
`endif

endmodule

/* tb/testbench.sv */
// testbench for smooth_band_color_blend_core: directed band cases, then random phases and a quiet tail
// predicts each color from its own copy of the registers; needs sbcb_pkg and the core
`timescale 1ns / 1ps

module testbench import sbcb_pkg::*; ();

   localparam int FRAC_BITS = 12;
   localparam int LATENCY   = FRAC_BITS + 7;
   localparam int LIMIT     = 400000;
   localparam longint ONE   = longint'(1) << FRAC_BITS;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CHAN_W-1:0]    rsp_out_red;
   logic [CHAN_W-1:0]    rsp_out_green;
   logic [CHAN_W-1:0]    rsp_out_blue;
   logic [CHAN_W-1:0]    rsp_out_alpha;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COLOR_W-1:0]   csr_wr_data;

   // shadow copy of the block registers
   band_cfg_type  band_m;
   color_cfg_type color_m;

   logic [COLOR_W-1:0] expected_colors[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  stall_left = 0;
   bit  quiet_mode = 0;
   string chan_name[NUM_CHAN] = '{"red", "green", "blue", "alpha"};

   smooth_band_color_blend_core #(.FRAC_BITS(FRAC_BITS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // smoothstep weight of a ramp position
   function automatic longint ramp_weight(longint num, longint den);
      longint t, t2, t3, w;
      if (den <= 0 || num < 0)
         return 0;
      t = (num * ONE) / den;
      if (t > ONE)
         t = ONE;
      t2 = (t * t) / ONE;
      t3 = (t2 * t) / ONE;
      w = 3 * t2 - 2 * t3;
      if (w < 0)
         w = 0;
      if (w > ONE)
         w = ONE;
      return w;
   endfunction

   // expected color for one sample under the shadow registers
   function automatic logic [COLOR_W-1:0] blend_color(logic [SAMPLE_W-1:0] sample);
      longint x, lt, ut, lo, hi, w, swap, ca, cb, r;
      logic [COLOR_W-1:0] a, b, color;
      x  = longint'($signed(sample));
      lt = longint'($signed(band_m.lower_thr));
      ut = longint'($signed(band_m.upper_thr));
      lo = lt - longint'($signed(band_m.lower_soft));
      hi = ut + longint'($signed(band_m.upper_soft));
      // clamp the inner lower edge, then put each edge pair in order
      if (lt > ut)
         lt = ut;
      if (lt < lo) begin
         swap = lo; lo = lt; lt = swap;
      end
      if (ut > hi) begin
         swap = hi; hi = ut; ut = swap;
      end
      if (x >= lt && x <= ut)
         w = ONE;
      else if (x <= lo || x >= hi)
         w = 0;
      else if (x < lt)
         w = ramp_weight(x - lo, lt - lo);
      else
         w = ONE - ramp_weight(x - ut, hi - ut);
      a = color_m.invert ? color_m.inner : color_m.outside;
      b = color_m.invert ? color_m.outside : color_m.inner;
      for (int k = 0; k < NUM_CHAN; k++) begin
         ca = longint'(a[COLOR_W-1-CHAN_W*k -: CHAN_W]);
         cb = longint'(b[COLOR_W-1-CHAN_W*k -: CHAN_W]);
         r = (ca * (ONE - w) + cb * w + (ONE >> 1)) / ONE;
         if (r < 0)
            r = 0;
         if (r > 65535)
            r = 65535;
         color[COLOR_W-1-CHAN_W*k -: CHAN_W] = r[CHAN_W-1:0];
      end
      return color;
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // result checking and prediction of accepted items
   always @(posedge clock) begin : color_check
      logic [COLOR_W-1:0] got, want;
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL smooth_band_color_blend_core");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha};
            if (expected_colors.size() == 0) begin
               note_mismatch($sformatf("unexpected item %h", got));
            end else begin
               want = expected_colors.pop_front();
               for (int k = 0; k < NUM_CHAN; k++)
                  if (got[COLOR_W-1-CHAN_W*k -: CHAN_W] !== want[COLOR_W-1-CHAN_W*k -: CHAN_W])
                     note_mismatch($sformatf("%s expected %h actual %h", chan_name[k],
                        want[COLOR_W-1-CHAN_W*k -: CHAN_W], got[COLOR_W-1-CHAN_W*k -: CHAN_W]));
            end
         end
         if (req_valid && req_ready)
            expected_colors.push_back(blend_color(req_sample_value));
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (quiet_mode || stall_pct == 0) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one item on the input channel, with an optional gap before it
   task automatic send_item(logic [SAMPLE_W-1:0] sample);
      int n;
      if (!quiet_mode && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         n = $urandom_range(1, 16);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_sample_value <= sample;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // stop sending and wait until every color is back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_colors.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         REG_LOWER_THR:  band_m.lower_thr  = data[SAMPLE_W-1:0];
         REG_UPPER_THR:  band_m.upper_thr  = data[SAMPLE_W-1:0];
         REG_LOWER_SOFT: band_m.lower_soft = data[SAMPLE_W-1:0];
         REG_UPPER_SOFT: band_m.upper_soft = data[SAMPLE_W-1:0];
         REG_INSIDE:     color_m.inner     = data;
         REG_OUTSIDE:    color_m.outside   = data;
         REG_INVERT:     color_m.invert    = data[0];
         default: ;
      endcase
   endtask

   // upper bits of narrow registers carry junk that must be dropped
   task automatic set_band(int lt, int ut, int lsw, int usw);
      logic [COLOR_W-1:0] junk;
      junk = {$urandom, $urandom};
      write_reg(REG_LOWER_THR,  {junk[63:16], 16'(lt)});
      write_reg(REG_UPPER_THR,  {junk[63:16], 16'(ut)});
      write_reg(REG_LOWER_SOFT, {junk[47:0], 16'(lsw)});
      write_reg(REG_UPPER_SOFT, {junk[31:0], junk[63:48], 16'(usw)});
   endtask

   task automatic set_colors(logic [COLOR_W-1:0] inner, logic [COLOR_W-1:0] outside,
                             bit invert);
      write_reg(REG_INSIDE, inner);
      write_reg(REG_OUTSIDE, outside);
      write_reg(REG_INVERT, {$urandom, $urandom_range(0, 1) ? 32'hFFFF_FFFE : 32'h0} | invert);
   endtask

   function automatic int pick_edge();
      case ($urandom_range(0, 9))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(0, 16383)) - 8192;
      endcase
   endfunction

   function automatic int pick_soft();
      case ($urandom_range(0, 11))
         0:       return -32768;
         1:       return 32767;
         2, 3:    return -int'($urandom_range(0, 2048));
         4:       return 0;
         default: return int'($urandom_range(1, 2048));
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // sample near one of the band edges, now and then anywhere
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int lt, ut, anchor, x;
      if ($urandom_range(0, 99) < 15)
         return SAMPLE_W'($urandom);
      lt = int'($signed(band_m.lower_thr));
      ut = int'($signed(band_m.upper_thr));
      case ($urandom_range(0, 3))
         0:       anchor = lt;
         1:       anchor = ut;
         2:       anchor = lt - int'($signed(band_m.lower_soft));
         default: anchor = ut + int'($signed(band_m.upper_soft));
      endcase
      x = anchor + int'($urandom_range(0, 4096)) - 2048;
      if (x < -32768)
         x = -32768;
      if (x > 32767)
         x = 32767;
      return SAMPLE_W'(x);
   endfunction

   // reset values: both ramps, the edges and the field extremes
   task automatic test_reset_values;
      gap_pct = 30;
      stall_pct = 30;
      send_item(16'sd1433);
      send_item(16'sd1500);
      send_item(16'sd1638);
      send_item(16'sd1800);
      send_item(16'sd2048);
      send_item(16'sd2150);
      send_item(16'sd2253);
      send_item(16'h8000);
      send_item(16'h7FFF);
      drain();
   endtask

   // widest band and extreme soft widths
   task automatic test_field_extremes;
      set_band(-32768, 32767, 32767, -32768);
      set_colors('1, '0, 0);
      send_item(16'h8000);
      send_item(16'h0000);
      send_item(16'hFFFF);
      send_item(16'h7FFF);
      drain();
   endtask

   // negative soft widths push the outer edges inside, the swap fixes the order
   task automatic test_negative_widths;
      set_band(0, 1000, -400, -500);
      set_colors(64'h1234_FFFF_0000_8000, 64'hFFFF_0000_ABCD_0001, 0);
      send_item(16'sd200);
      send_item(16'sd450);
      send_item(16'sd700);
      send_item(16'sd900);
      drain();
   endtask

   // inner edges crossed, then crossed again after the swap
   task automatic test_crossed_edges;
      set_band(3000, -2000, 300, 300);
      send_item(-16'sd2100);
      send_item(-16'sd2000);
      send_item(-16'sd1900);
      drain();
      set_band(1000, 1200, -500, 200);
      send_item(16'sd1100);
      send_item(16'sd1300);
      send_item(16'sd1600);
      drain();
   endtask

   // inverted colors and a write to an unused index
   task automatic test_invert_and_index;
      set_band(-1000, 1000, 1000, 1000);
      set_colors('1, '0, 1);
      write_reg(REG_UNUSED, '1);
      send_item(16'sd0);
      send_item(-16'sd1500);
      send_item(16'sd1700);
      drain();
   endtask

   // random settings, each followed by a run of samples around the band
   task automatic test_random_phases;
      for (int p = 0; p < 12; p++) begin
         case (p % 3)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 25; stall_pct = 25; end
            default: begin gap_pct = 60; stall_pct = 60; end
         endcase
         set_band(pick_edge(), pick_edge(), pick_soft(), pick_soft());
         set_colors(pick_color(), pick_color(), 1'($urandom_range(0, 1)));
         repeat (100) send_item(pick_sample());
         drain();
      end
   endtask

   // last stretch at full rate with no idling at all
   task automatic test_quiet_tail;
      quiet_mode = 1;
      set_band(-4096, 4096, 1024, 2048);
      set_colors(pick_color(), pick_color(), 0);
      repeat (50) send_item(pick_sample());
      drain();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      rsp_ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wr_data      = '0;
      band_m  = '{RST_LOWER_THR, RST_UPPER_THR, RST_LOWER_SOFT, RST_UPPER_SOFT};
      color_m = '{RST_INSIDE, RST_OUTSIDE, 1'b0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_field_extremes();
      test_negative_widths();
      test_crossed_edges();
      test_invert_and_index();
      test_random_phases();
      test_quiet_tail();

      if (mismatch_count == 0)
         $display("PASS smooth_band_color_blend_core");
      else
         $display("FAIL smooth_band_color_blend_core");
      $finish;
   end

endmodule

/* smooth_band_color_blend_core.f */
hdl/sbcb_pkg.sv
hdl/sbcb_edge.sv
hdl/sbcb_div.sv
hdl/sbcb_weight.sv
hdl/sbcb_mix.sv
hdl/smooth_band_color_blend_core.sv
tb/testbench.sv
